/* rtl/fqs_pkg.sv */
package fqs_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_ENQ  = 2'd0,
		MODE_DEQ  = 2'd1,
		MODE_FIND = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_NOMATCH = 3'd3,
		ST_MATCH   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DEQ,
		S_FIND,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic [1:0]   mode;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		status_t      status;
		logic signed [31:0] data;
		logic [4:0]   position;
		logic [4:0]   occupancy;
		logic         last;
	} rsp_t;

	// ring increment, wraps at the last entry
	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] r;
		if (idx == IDX_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = idx + IDX_W'(1);
		end
		return r;
	endfunction

	// ring add for head plus count, count at most depth
	function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] idx,
			input logic [CNT_W-1:0] cnt);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(idx) + (CNT_W+1)'(cnt);
		if (sum >= (CNT_W+1)'(DEPTH)) begin
			sum = sum - (CNT_W+1)'(DEPTH);
		end
		return IDX_W'(sum);
	endfunction

endpackage

/* rtl/fifo_queue_with_search.sv */
// bounded first-in first-out queue of signed 32-bit values with a key search
// request channel: req (mode, value) is taken at a rising edge with start high
// and busy low. results: rsp is shown for one cycle with valid high; the
// receiver cannot hold them off, so every result appears exactly once.
// enqueue: result in the cycle after the request, busy stays low.
// dequeue: result registered from one ram read, busy high in state S_DEQ;
// on an empty queue the empty result comes in the cycle after the request.
// find: walks the stored entries through the ram read port, one entry a
// cycle, oldest first; busy in states S_FIND and S_FLUSH, then idle, the
// final result shown in the first idle cycle; on an empty queue busy stays
// low and the no-match result comes in the cycle after the request. one match
// result per equal entry, the final one carrying last, or a single no-match.
// a match is held back one compare so that last can be set on the final one.
// a request may be taken while the previous result is still on rsp.
// reset clears head, fill count and control; the entry ram has no reset
// and its read data is only used from entries that hold a stored value.
module fifo_queue_with_search (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  fqs_pkg::req_t req,
	output logic          busy,
	output logic          valid,
	output fqs_pkg::rsp_t rsp
);

	fqs_pkg::state_t state_q, state_d;

	logic [fqs_pkg::IDX_W-1:0] head_q, head_d;
	logic [fqs_pkg::CNT_W-1:0] count_q, count_d;
	logic [fqs_pkg::IDX_W-1:0] rptr_q;
	logic [fqs_pkg::CNT_W-1:0] pos_q;
	logic [fqs_pkg::CNT_W-1:0] ppos_q, ppos_d;
	logic                      pend_q, pend_d;
	logic [31:0]               key_q;

	logic                      valid_q, valid_d;
	fqs_pkg::rsp_t             rsp_q, rsp_d;

	logic                      ram_we;
	logic [fqs_pkg::IDX_W-1:0] ram_waddr;
	logic [fqs_pkg::IDX_W-1:0] ram_raddr;
	logic [31:0]               ram_rdata;

	logic accept;

	assign busy   = (state_q != fqs_pkg::S_IDLE);
	assign accept = start && (state_q == fqs_pkg::S_IDLE);
	assign valid  = valid_q;
	assign rsp    = rsp_q;

	fqs_ram #(
		.WIDTH (32),
		.DEPTH (fqs_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req.value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign ram_waddr = fqs_pkg::idx_add(head_q, count_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fqs_pkg::S_IDLE: begin
				if (accept) begin
					case (req.mode)
						fqs_pkg::MODE_DEQ: begin
							if (count_q != '0) begin
								state_d = fqs_pkg::S_DEQ;
							end
						end
						fqs_pkg::MODE_FIND: begin
							if (count_q != '0) begin
								state_d = fqs_pkg::S_FIND;
							end
						end
						default: begin
							state_d = fqs_pkg::S_IDLE;
						end
					endcase
				end
			end
			fqs_pkg::S_DEQ: begin
				state_d = fqs_pkg::S_IDLE;
			end
			fqs_pkg::S_FIND: begin
				if (pos_q == count_q) begin
					state_d = fqs_pkg::S_FLUSH;
				end
			end
			fqs_pkg::S_FLUSH: begin
				state_d = fqs_pkg::S_IDLE;
			end
			default: begin
				state_d = fqs_pkg::S_IDLE;
			end
		endcase
	end

	// datapath and result
	always_comb begin
		ram_we    = 1'b0;
		ram_raddr = head_q;
		head_d    = head_q;
		count_d   = count_q;
		pend_d    = pend_q;
		ppos_d    = ppos_q;
		valid_d   = 1'b0;
		rsp_d.status    = fqs_pkg::ST_OK;
		rsp_d.data      = '0;
		rsp_d.position  = '0;
		rsp_d.occupancy = 5'(count_q);
		rsp_d.last      = 1'b1;
		case (state_q)
			fqs_pkg::S_IDLE: begin
				if (accept) begin
					case (req.mode)
						fqs_pkg::MODE_ENQ: begin
							valid_d = 1'b1;
							if (count_q == fqs_pkg::CNT_W'(fqs_pkg::DEPTH)) begin
								rsp_d.status = fqs_pkg::ST_FULL;
							end else begin
								ram_we          = 1'b1;
								count_d         = count_q + fqs_pkg::CNT_W'(1);
								rsp_d.occupancy = 5'(count_d);
							end
						end
						fqs_pkg::MODE_DEQ: begin
							if (count_q == '0) begin
								valid_d      = 1'b1;
								rsp_d.status = fqs_pkg::ST_EMPTY;
							end
						end
						fqs_pkg::MODE_FIND: begin
							pend_d = 1'b0;
							if (count_q == '0) begin
								valid_d      = 1'b1;
								rsp_d.status = fqs_pkg::ST_NOMATCH;
							end
						end
						default: begin
							valid_d = 1'b1;
						end
					endcase
				end
			end
			fqs_pkg::S_DEQ: begin
				valid_d         = 1'b1;
				head_d          = fqs_pkg::idx_inc(head_q);
				count_d         = count_q - fqs_pkg::CNT_W'(1);
				rsp_d.data      = $signed(ram_rdata);
				rsp_d.occupancy = 5'(count_d);
			end
			fqs_pkg::S_FIND: begin
				// read one entry ahead of the compare
				ram_raddr = fqs_pkg::idx_inc(rptr_q);
				if (ram_rdata == key_q) begin
					if (pend_q) begin
						valid_d        = 1'b1;
						rsp_d.status   = fqs_pkg::ST_MATCH;
						rsp_d.position = 5'(ppos_q);
						rsp_d.last     = 1'b0;
					end
					pend_d = 1'b1;
					ppos_d = pos_q;
				end
			end
			fqs_pkg::S_FLUSH: begin
				valid_d = 1'b1;
				if (pend_q) begin
					rsp_d.status   = fqs_pkg::ST_MATCH;
					rsp_d.position = 5'(ppos_q);
				end else begin
					rsp_d.status = fqs_pkg::ST_NOMATCH;
				end
			end
			default: begin
				valid_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fqs_pkg::S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			pend_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			pend_q  <= pend_d;
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q  <= rsp_d;
		ppos_q <= ppos_d;
		if (state_q == fqs_pkg::S_IDLE) begin
			rptr_q <= head_q;
			pos_q  <= fqs_pkg::CNT_W'(1);
			key_q  <= req.value;
		end else if (state_q == fqs_pkg::S_FIND) begin
			rptr_q <= fqs_pkg::idx_inc(rptr_q);
			pos_q  <= pos_q + fqs_pkg::CNT_W'(1);
		end
	end

endmodule

/* rtl/fqs_ram.sv */
module fqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/fqs_chk.sv */
module fqs_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input fqs_pkg::req_t req,
	input logic          busy,
	input logic          valid,
	input fqs_pkg::rsp_t rsp
);

	// busy only ever follows a taken request
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a request");

	// a request that leaves the block idle has answered at once
	a_single_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) ##1 !busy |-> valid && rsp.last)
		else $error("idle after request without a final result");

	// a non-final result is only shown while the request is still running
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !rsp.last |-> busy)
		else $error("non-final result but block went idle");

	// finishing a long request shows its final result
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> valid && rsp.last)
		else $error("busy fell without a final result");

	// a match carries a position and no data
	a_match_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid && rsp.status == fqs_pkg::ST_MATCH |-> rsp.position != '0 && rsp.data == '0)
		else $error("match result with bad fields");

endmodule

bind fifo_queue_with_search fqs_chk u_fqs_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.req    (req),
	.busy   (busy),
	.valid  (valid),
	.rsp    (rsp)
);

/* dv/fifo_queue_with_search_tb.sv */
`timescale 1ns / 100ps

module fifo_queue_with_search_tb;
	import fqs_pkg::*;

	// mode code the block does not decode
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int RANDOM_REQS = 435;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = DEPTH + 8;

	class queue_shadow;
		logic signed [31:0] ring [DEPTH];
		int unsigned head = 0;
		int unsigned fill = 0;
		rsp_t expected_rsp [$];
		int unsigned faults = 0;
		int unsigned results = 0;
		int unsigned status_hits [5];
		int unsigned mode_hits [4];

		function void note_request(req_t r);
			rsp_t e;
			int unsigned first;
			e = '0;
			e.status = ST_OK;
			e.last = 1'b1;
			mode_hits[r.mode]++;
			case (r.mode)
				MODE_ENQ: begin
					if (fill >= DEPTH) begin
						e.status = ST_FULL;
					end else begin
						ring[(head + fill) % DEPTH] = r.value;
						fill++;
					end
					e.occupancy = 5'(fill);
					expected_rsp.push_back(e);
				end
				MODE_DEQ: begin
					if (fill == 0) begin
						e.status = ST_EMPTY;
					end else begin
						e.data = ring[head];
						head = (head + 1) % DEPTH;
						fill--;
					end
					e.occupancy = 5'(fill);
					expected_rsp.push_back(e);
				end
				MODE_FIND: begin
					first = expected_rsp.size();
					e.occupancy = 5'(fill);
					for (int i = 0; i < fill; i++) begin
						if (ring[(head + i) % DEPTH] == r.value) begin
							e.status = ST_MATCH;
							e.position = 5'(i + 1);
							e.last = 1'b0;
							expected_rsp.push_back(e);
						end
					end
					if (expected_rsp.size() == first) begin
						e.status = ST_NOMATCH;
						e.position = '0;
						e.last = 1'b1;
						expected_rsp.push_back(e);
					end else begin
						expected_rsp[expected_rsp.size() - 1].last = 1'b1;
					end
				end
				default: begin
					e.occupancy = 5'(fill);
					expected_rsp.push_back(e);
				end
			endcase
		endfunction

		function void check_result(rsp_t got);
			rsp_t e;
			results++;
			if (expected_rsp.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result: status %0d data %0d pos %0d occ %0d last %0d",
						got.status, got.data, got.position, got.occupancy, got.last);
				return;
			end
			e = expected_rsp.pop_front();
			status_hits[e.status]++;
			if (got.status !== e.status || got.data !== e.data ||
					got.position !== e.position || got.occupancy !== e.occupancy ||
					got.last !== e.last) begin
				faults++;
				if (faults <= 10) begin
					$display("mismatch: exp status %0d data %0d pos %0d occ %0d last %0d",
						e.status, e.data, e.position, e.occupancy, e.last);
					$display("          got status %0d data %0d pos %0d occ %0d last %0d",
						got.status, got.data, got.position, got.occupancy, got.last);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic valid;
	rsp_t rsp;

	queue_shadow shadow = new();
	int unsigned cycles = 0;
	bit quiet = 1'b0;

	fifo_queue_with_search u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.valid  (valid),
		.rsp    (rsp)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d results outstanding",
				cycles, shadow.expected_rsp.size());
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && valid)
			shadow.check_result(rsp);
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// extremes and a few small values so that finds hit repeatedly
	function automatic logic signed [31:0] pooled_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return -32'sd1;
			3: return '0;
			4, 5, 6: return 32'($urandom_range(1, 4));
			default: return $urandom;
		endcase
	endfunction

	// start is left high so that a back-to-back request keeps it up
	task automatic send_request(input logic [1:0] mode, input logic signed [31:0] value);
		req_t r;
		int gap;
		r.mode = mode;
		r.value = value;
		gap = quiet ? 0 : idle_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		shadow.note_request(r);
	endtask

	initial begin
		int random_reqs;
		int pick;
		bit filling;
		logic signed [31:0] key;
		random_reqs = 0;
		filling = 1'b1;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty queue corner cases, then fill to the brim
		send_request(MODE_DEQ, 32'sd9);
		send_request(MODE_FIND, 32'sd5);
		send_request(MODE_SPARE, 32'sd77);
		send_request(MODE_ENQ, 32'sh7fffffff);
		send_request(MODE_ENQ, 32'sh80000000);
		send_request(MODE_ENQ, -32'sd1);
		send_request(MODE_ENQ, '0);
		for (int i = 0; i < 12; i++)
			send_request(MODE_ENQ, (i % 4 == 1 || i == 11) ? 32'sd5 :
				32'($urandom_range(100, 200)));
		send_request(MODE_ENQ, 32'sd7);
		send_request(MODE_FIND, 32'sd5);
		send_request(MODE_FIND, -32'sd1);
		send_request(MODE_FIND, 32'sd12345);
		send_request(MODE_DEQ, '0);
		send_request(MODE_FIND, 32'sh80000000);

		while (random_reqs < RANDOM_REQS) begin
			quiet = ((random_reqs / 40) % 4) == 2;
			if (shadow.fill == DEPTH && $urandom_range(0, 3) == 0)
				filling = 1'b0;
			else if (shadow.fill == 0 && $urandom_range(0, 3) == 0)
				filling = 1'b1;
			else if ($urandom_range(0, 49) == 0)
				filling = !filling;
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				send_request(MODE_SPARE, $urandom);
			end else if (pick < 27) begin
				// keys mostly taken from what is stored
				if (shadow.fill > 0 && $urandom_range(0, 2) != 0)
					key = shadow.ring[(shadow.head + $urandom_range(0, shadow.fill - 1)) % DEPTH];
				else
					key = pooled_value();
				send_request(MODE_FIND, key);
				random_reqs++;
			end else if (pick < (filling ? 82 : 45)) begin
				send_request(MODE_ENQ, pooled_value());
				random_reqs++;
			end else begin
				send_request(MODE_DEQ, $urandom);
				random_reqs++;
			end
		end
		start <= 1'b0;

		while (shadow.expected_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests (%0d enqueue, %0d dequeue, %0d find, %0d unused), %0d results",
			shadow.mode_hits[0] + shadow.mode_hits[1] + shadow.mode_hits[2] + shadow.mode_hits[3],
			shadow.mode_hits[0], shadow.mode_hits[1], shadow.mode_hits[2], shadow.mode_hits[3],
			shadow.results);
		$display("full %0d, empty %0d, match %0d, no match %0d, faults %0d",
			shadow.status_hits[ST_FULL], shadow.status_hits[ST_EMPTY],
			shadow.status_hits[ST_MATCH], shadow.status_hits[ST_NOMATCH], shadow.faults);
		if (shadow.faults == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
